### rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// shared constants for the lru page replacement unit
// ----------------------------------------------------------------------------
package lrupr_pkg;

   // frame count register
   localparam int unsigned CSR_BITS = 3;
   localparam logic [CSR_BITS-1:0] FRAMES_IN_USE_RESET = 3'd4;
   localparam logic [CSR_BITS-1:0] FRAMES_IN_USE_MIN = 3'd1;

   // stage valid flag
   typedef struct packed {
      logic valid;
   } lrupr_flag_type;

endpackage

### rtl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// lru page replacement unit with hit/miss reporting and saturating totals
// ----------------------------------------------------------------------------
// usage
//   req_* : one page reference per request, page number in req_tdata
//   rsp_* : one result per request, fields in rsp_tdata (see port comment)
//   csr_* : frames_in_use register, written while the unit is idle
// path: input register, then lookup/update, then result register
// throughput: one request per cycle while the receiver does not stall; the frame
//   compare, victim pick and rank update all sit in the single stage
//   between the two registers
// reset: all frames empty, ranks and totals zero, frames_in_use = 4
// receiver stall: the result register holds, the input register still takes
//   one more request, then req_tready drops until rsp_tready returns
// frames_in_use of 0 acts as 1, values above NUM_FRAMES act as NUM_FRAMES;
// frames out of use keep their contents and are not searched or replaced
// ----------------------------------------------------------------------------
module lru_page_replacement
   import lrupr_pkg::*;
#(
   parameter int unsigned NUM_FRAMES = 4,
   parameter int unsigned PAGE_BITS  = 16,
   parameter int unsigned COUNT_BITS = 16,
   localparam int unsigned SLOT_BITS = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
   localparam int unsigned REQ_W     = ((PAGE_BITS + 7) / 8) * 8,
   localparam int unsigned RSP_BITS  = 2 + SLOT_BITS + PAGE_BITS + 2 * COUNT_BITS,
   localparam int unsigned RSP_W     = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic clock,
   input  logic reset,

   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_W-1:0]              req_tdata,   // page_number

   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // hit, frame_slot, evicted_valid, evicted_page, hit_total, miss_total
   output logic [RSP_W-1:0]              rsp_tdata,

   // configuration
   input  logic                          csr_wr_en,
   input  logic [CSR_BITS-1:0]           csr_wr_data  // frames_in_use
);

   localparam logic [SLOT_BITS-1:0] MAX_RANK = SLOT_BITS'(NUM_FRAMES - 1);

   // configuration register
   logic [CSR_BITS-1:0] frames_in_use_ff;

   // frame table
   logic [PAGE_BITS-1:0] frame_page_ff [NUM_FRAMES];
   logic [PAGE_BITS-1:0] frame_page_in [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] frame_valid_ff, frame_valid_in;
   logic [SLOT_BITS-1:0] rank_ff [NUM_FRAMES];
   logic [SLOT_BITS-1:0] rank_in [NUM_FRAMES];
   logic [COUNT_BITS-1:0] hit_count_ff, hit_count_in;
   logic [COUNT_BITS-1:0] miss_count_ff, miss_count_in;

   // input register
   lrupr_flag_type        in_stage_ff;
   logic [PAGE_BITS-1:0]  in_page_ff;

   // result register
   lrupr_flag_type        out_stage_ff;
   logic                  out_hit_ff, out_hit_in;
   logic [SLOT_BITS-1:0]  out_slot_ff, out_slot_in;
   logic                  out_ev_valid_ff, out_ev_valid_in;
   logic [PAGE_BITS-1:0]  out_ev_page_ff, out_ev_page_in;

   logic advance;
   logic req_accept;

   // lookup signals
   logic [CSR_BITS-1:0]   n_eff;
   logic [NUM_FRAMES-1:0] active;
   logic                  hit_found, empty_found;
   logic [SLOT_BITS-1:0]  hit_slot, empty_slot, victim_slot, best_rank, sel_slot;
   logic [SLOT_BITS-1:0]  old_rank;
   logic                  use_old_rank;

   assign advance    = in_stage_ff.valid && (!out_stage_ff.valid || rsp_tready);
   assign req_tready = !in_stage_ff.valid || advance;
   assign req_accept = req_tvalid && req_tready;

   // active frame count: 0 acts as 1, values above NUM_FRAMES enable all frames
   assign n_eff = (frames_in_use_ff == '0) ? FRAMES_IN_USE_MIN : frames_in_use_ff;

   always_comb begin
      for (int g = 0; g < NUM_FRAMES; g++) begin
         active[g] = (g < int'(n_eff));
      end
   end

   // lowest matching frame and lowest empty frame among the active frames
   always_comb begin
      hit_found   = 1'b0;
      hit_slot    = '0;
      empty_found = 1'b0;
      empty_slot  = '0;
      for (int g = NUM_FRAMES - 1; g >= 0; g--) begin
         if (active[g] && frame_valid_ff[g] && (frame_page_ff[g] == in_page_ff)) begin
            hit_found = 1'b1;
            hit_slot  = SLOT_BITS'(g);
         end
         if (active[g] && !frame_valid_ff[g]) begin
            empty_found = 1'b1;
            empty_slot  = SLOT_BITS'(g);
         end
      end
   end

   // largest rank wins, ties go to the lower frame
   always_comb begin
      best_rank   = '0;
      victim_slot = '0;
      for (int g = 0; g < NUM_FRAMES; g++) begin
         if (active[g] && (rank_ff[g] > best_rank)) begin
            best_rank   = rank_ff[g];
            victim_slot = SLOT_BITS'(g);
         end
      end
   end

   always_comb begin
      if (hit_found) begin
         sel_slot = hit_slot;
      end else if (empty_found) begin
         sel_slot = empty_slot;
      end else begin
         sel_slot = victim_slot;
      end
      // on a miss every other active valid frame ages
      use_old_rank = hit_found;
      old_rank     = rank_ff[hit_slot];
   end

   // next state of the frame table, totals and result fields
   always_comb begin
      frame_page_in  = frame_page_ff;
      frame_valid_in = frame_valid_ff;
      rank_in        = rank_ff;
      hit_count_in   = hit_count_ff;
      miss_count_in  = miss_count_ff;

      out_hit_in      = hit_found;
      out_slot_in     = sel_slot;
      out_ev_valid_in = !hit_found && !empty_found;
      out_ev_page_in  = out_ev_valid_in ? frame_page_ff[victim_slot] : '0;

      if (!hit_found) begin
         frame_page_in[sel_slot]  = in_page_ff;
         frame_valid_in[sel_slot] = 1'b1;
      end

      for (int g = 0; g < NUM_FRAMES; g++) begin
         if (active[g] && (SLOT_BITS'(g) != sel_slot) && frame_valid_ff[g] &&
             (!use_old_rank || (rank_ff[g] < old_rank)) && (rank_ff[g] < MAX_RANK)) begin
            rank_in[g] = rank_ff[g] + 1'b1;
         end
      end
      rank_in[sel_slot] = '0;

      if (hit_found) begin
         if (hit_count_ff != '1) begin
            hit_count_in = hit_count_ff + 1'b1;
         end
      end else begin
         if (miss_count_ff != '1) begin
            miss_count_in = miss_count_ff + 1'b1;
         end
      end
   end

   // control and table state
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff  <= FRAMES_IN_USE_RESET;
         in_stage_ff.valid <= 1'b0;
         out_stage_ff.valid <= 1'b0;
         frame_valid_ff    <= '0;
         hit_count_ff      <= '0;
         miss_count_ff     <= '0;
         for (int g = 0; g < NUM_FRAMES; g++) begin
            rank_ff[g] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            frames_in_use_ff <= csr_wr_data;
         end
         if (req_accept) begin
            in_stage_ff.valid <= 1'b1;
         end else if (advance) begin
            in_stage_ff.valid <= 1'b0;
         end
         if (advance) begin
            out_stage_ff.valid <= 1'b1;
            frame_valid_ff     <= frame_valid_in;
            rank_ff            <= rank_in;
            hit_count_ff       <= hit_count_in;
            miss_count_ff      <= miss_count_in;
         end else if (rsp_tready) begin
            out_stage_ff.valid <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_page_ff <= req_tdata[PAGE_BITS-1:0];
      end
      if (advance) begin
         frame_page_ff   <= frame_page_in;
         out_hit_ff      <= out_hit_in;
         out_slot_ff     <= out_slot_in;
         out_ev_valid_ff <= out_ev_valid_in;
         out_ev_page_ff  <= out_ev_page_in;
      end
   end

   // totals in the result are the counters after this request
   assign rsp_tvalid = out_stage_ff.valid;
   assign rsp_tdata  = RSP_W'({miss_count_ff, hit_count_ff, out_ev_page_ff,
                               out_ev_valid_ff, out_slot_ff, out_hit_ff});

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lru page replacement unit: directed page
// references with known outcomes, then random working-set traffic under
// random sender gaps and receiver stalls, frame count changes between
// phases
// ----------------------------------------------------------------------------
module tb_top;
   import lrupr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NUM_FRAMES  = 4;
   localparam int unsigned MAX_RANK    = NUM_FRAMES - 1;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
   localparam int unsigned LATENCY     = 2;
   localparam int unsigned LONG_HOLD   = 64;     // receiver hold-off, cycles
   localparam int unsigned MAX_REPORTS = 20;
   localparam int unsigned NUM_PHASES  = 10;
   localparam int unsigned PHASE_LEN   = 50;

   // one result as the unit reports it
   typedef struct packed {
      logic        hit;
      logic [1:0]  frame_slot;
      logic        evicted_valid;
      logic [15:0] evicted_page;
      logic [15:0] hit_total;
      logic [15:0] miss_total;
   } lookup_result_type;

   // one row of the directed sequence: optional frame count write first,
   // then a page reference, with the outcome typed in where it is obvious
   typedef struct packed {
      logic                cfg_now;
      logic [CSR_BITS-1:0] cfg_val;
      logic [15:0]         page;
      logic                pinned;
      lookup_result_type   want;
   } warmup_row_type;

   localparam int unsigned NUM_ROWS = 22;

   // frame fill from reset, lru victims, frames out of use, zero and
   // oversized frame counts, rank ties, narrow frame counts
   warmup_row_type warmup_rows [NUM_ROWS] = '{
      '{1'b0, 3'd0, 16'h0000, 1'b1, '{1'b0, 2'd0, 1'b0, 16'h0000, 16'd0, 16'd1}},
      '{1'b0, 3'd0, 16'hFFFF, 1'b1, '{1'b0, 2'd1, 1'b0, 16'h0000, 16'd0, 16'd2}},
      '{1'b0, 3'd0, 16'h0000, 1'b1, '{1'b1, 2'd0, 1'b0, 16'h0000, 16'd1, 16'd2}},
      '{1'b0, 3'd0, 16'h1234, 1'b1, '{1'b0, 2'd2, 1'b0, 16'h0000, 16'd1, 16'd3}},
      '{1'b0, 3'd0, 16'hABCD, 1'b1, '{1'b0, 2'd3, 1'b0, 16'h0000, 16'd1, 16'd4}},
      '{1'b0, 3'd0, 16'h5555, 1'b1, '{1'b0, 2'd1, 1'b1, 16'hFFFF, 16'd1, 16'd5}},
      '{1'b0, 3'd0, 16'hAAAA, 1'b1, '{1'b0, 2'd0, 1'b1, 16'h0000, 16'd1, 16'd6}},
      '{1'b0, 3'd0, 16'h1234, 1'b1, '{1'b1, 2'd2, 1'b0, 16'h0000, 16'd2, 16'd6}},
      '{1'b1, 3'd1, 16'hAAAA, 1'b1, '{1'b1, 2'd0, 1'b0, 16'h0000, 16'd3, 16'd6}},
      '{1'b0, 3'd0, 16'h5555, 1'b1, '{1'b0, 2'd0, 1'b1, 16'hAAAA, 16'd3, 16'd7}},
      '{1'b1, 3'd0, 16'h5555, 1'b1, '{1'b1, 2'd0, 1'b0, 16'h0000, 16'd4, 16'd7}},
      '{1'b1, 3'd7, 16'h1234, 1'b0, '0},
      '{1'b0, 3'd0, 16'hFFFF, 1'b0, '0},
      '{1'b0, 3'd0, 16'h8001, 1'b0, '0},
      '{1'b0, 3'd0, 16'h7FFE, 1'b0, '0},
      '{1'b1, 3'd2, 16'h7FFE, 1'b0, '0},
      '{1'b0, 3'd0, 16'h0F0F, 1'b0, '0},
      '{1'b1, 3'd3, 16'hF0F0, 1'b0, '0},
      '{1'b0, 3'd0, 16'h0F0F, 1'b0, '0},
      '{1'b1, 3'd4, 16'h0001, 1'b0, '0},
      '{1'b0, 3'd0, 16'h8000, 1'b0, '0},
      '{1'b0, 3'd0, 16'hFFFF, 1'b0, '0}
   };

   // dut ports, the bench-driven ones known from time zero
   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata   = '0;   // page_number
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   // hit, frame_slot[2:1], evicted_valid, evicted_page[19:4],
   // hit_total[35:20], miss_total[51:36], zero fill
   logic [55:0]         rsp_tdata;
   logic                csr_wr_en   = 1'b0;
   logic [CSR_BITS-1:0] csr_wr_data = '0;   // frames_in_use

   // typed outcome travelling alongside the request being offered
   logic                pin_given   = 1'b0;
   lookup_result_type   pin_want    = '0;

   // bench-side copy of the frames, ranks, totals and frame count
   logic [15:0]         frame_page [NUM_FRAMES];
   logic                frame_full [NUM_FRAMES] = '{default: 1'b0};
   int unsigned         frame_rank [NUM_FRAMES] = '{default: 0};
   logic [15:0]         hit_count   = '0;
   logic [15:0]         miss_count  = '0;
   logic [CSR_BITS-1:0] frames_cfg  = FRAMES_IN_USE_RESET;

   lookup_result_type   expected_lookups [$];

   int unsigned errors      = 0;
   int unsigned n_requests  = 0;
   int unsigned n_results   = 0;
   int unsigned n_hits      = 0;
   int unsigned n_evictions = 0;
   int unsigned n_cfg       = 0;
   int unsigned burst_left  = 0;

   // receiver control shared with the stimulus process
   bit hold_off_req = 1'b0;

   lru_page_replacement i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // lru predictor
   // --------------------------------------------------------------------------

   // frame f becomes most recent; valid frames younger than its old rank age
   function automatic void promote_frame(input int unsigned f, input int unsigned old_rank,
                                         input int unsigned n);
      for (int unsigned g = 0; g < n; g++) begin
         if (g != f && frame_full[g] && frame_rank[g] < old_rank && frame_rank[g] < MAX_RANK)
            frame_rank[g]++;
      end
      frame_rank[f] = 0;
   endfunction

   function automatic void predict_lookup(input logic [15:0] page,
                                          output lookup_result_type r);
      int unsigned n;
      int unsigned slot;
      int unsigned best;
      logic        found;
      logic        empty_found;
      // zero acts as one, oversized counts clamp to the frame array
      n = (frames_cfg == 0) ? 1 : ((frames_cfg > NUM_FRAMES) ? NUM_FRAMES : frames_cfg);
      r = '0;
      found = 1'b0;
      empty_found = 1'b0;
      slot = 0;
      for (int unsigned f = 0; f < n; f++) begin
         if (!found && frame_full[f] && frame_page[f] == page) begin
            found = 1'b1;
            slot = f;
         end
      end
      if (found) begin
         promote_frame(slot, frame_rank[slot], n);
         if (hit_count != COUNT_MAX) hit_count++;
      end else begin
         for (int unsigned f = 0; f < n; f++) begin
            if (!empty_found && !frame_full[f]) begin
               empty_found = 1'b1;
               slot = f;
            end
         end
         // oldest rank wins, lowest frame on a tie
         if (!empty_found) begin
            best = 0;
            slot = 0;
            for (int unsigned f = 0; f < n; f++) begin
               if (frame_rank[f] > best) begin
                  best = frame_rank[f];
                  slot = f;
               end
            end
            r.evicted_valid = 1'b1;
            r.evicted_page  = frame_page[slot];
         end
         frame_page[slot] = page;
         frame_full[slot] = 1'b1;
         promote_frame(slot, NUM_FRAMES, n);
         if (miss_count != COUNT_MAX) miss_count++;
      end
      r.hit        = found;
      r.frame_slot = 2'(slot);
      r.hit_total  = hit_count;
      r.miss_total = miss_count;
   endfunction

   // --------------------------------------------------------------------------
   // monitor: sample at the rising edge, predict on acceptance, check results
   // --------------------------------------------------------------------------

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      lookup_result_type predicted;
      lookup_result_type want;
      lookup_result_type got;
      lookup_result_type queued;
      if (!reset) begin
         if (csr_wr_en) frames_cfg = csr_wr_data;

         // results first; the matching request was accepted and predicted at an earlier edge
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[0], rsp_tdata[2:1], rsp_tdata[3], rsp_tdata[19:4],
                    rsp_tdata[35:20], rsp_tdata[51:36]};
            n_results++;
            if (got.hit === 1'b1) n_hits++;
            if (got.evicted_valid === 1'b1) n_evictions++;
            if (expected_lookups.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t ns: result with no request outstanding, rsp_tdata %h",
                           $time, rsp_tdata);
            end else begin
               want = expected_lookups.pop_front();
               check_field("hit",           16'(want.hit),           16'(got.hit));
               check_field("frame_slot",    16'(want.frame_slot),    16'(got.frame_slot));
               check_field("evicted_valid", 16'(want.evicted_valid), 16'(got.evicted_valid));
               check_field("evicted_page",  want.evicted_page,       got.evicted_page);
               check_field("hit_total",     want.hit_total,          got.hit_total);
               check_field("miss_total",    want.miss_total,         got.miss_total);
            end
         end

         // the predictor always advances; a typed outcome replaces its answer
         if (req_tvalid && req_tready) begin
            n_requests++;
            predict_lookup(req_tdata, predicted);
            queued = pin_given ? pin_want : predicted;
            expected_lookups = {expected_lookups, queued};
         end
      end
   end

   // --------------------------------------------------------------------------
   // receiver: random ready pattern, long hold-off on request
   // --------------------------------------------------------------------------

   initial begin
      int unsigned seg_len;
      logic        seg_level;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            // hold off long enough that the unit fills and stalls its input
            repeat (LONG_HOLD) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
            hold_off_req = 1'b0;
         end else begin
            case ($urandom_range(0, 7))
               0:       begin seg_level = 1'b1; seg_len = $urandom_range(30, 60); end
               1, 2:    begin seg_level = 1'b0; seg_len = $urandom_range(1, 6);   end
               default: begin seg_level = 1'b1; seg_len = $urandom_range(1, 10);  end
            endcase
            repeat (seg_len) begin
               @(negedge clock);
               rsp_tready <= seg_level;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // sender side
   // --------------------------------------------------------------------------

   // offer one page at the falling edge, hold it until the handshake
   task automatic send_page(input logic [15:0] page, input logic given,
                            input lookup_result_type want);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= page;
      pin_given  <= given;
      pin_want   <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop offering and wait until every outstanding result has come back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // frame count change, only with the unit idle
   task automatic write_frames(input logic [CSR_BITS-1:0] value);
      drain_results();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      n_cfg++;
   endtask

   // bursts of random length, random gaps, now and then a full drain
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if ($urandom_range(0, 9) == 0) begin
            drain_results();
         end else begin
            repeat ($urandom_range(1, 8)) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
            end
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 15);
      end
   endtask

   // mostly references into a small working set so hits and lru victims
   // happen, with some fully random pages and some bit-pattern extremes
   function automatic logic [15:0] pick_page(input logic [15:0] pool [8],
                                             input int unsigned pool_len);
      int unsigned sel;
      int unsigned b;
      sel = $urandom_range(0, 9);
      b   = $urandom_range(0, 15);
      if (sel < 8)       return pool[$urandom_range(0, pool_len - 1)];
      else if (sel == 8) return 16'($urandom());
      else begin
         case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'(1 << b);
            default: return ~16'(1 << b);
         endcase
      end
   endfunction

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------

   initial begin
      logic [15:0] pool [8];
      int unsigned pool_len;
      int unsigned extra;
      int unsigned guard;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed rows, random short gaps between them
      for (int unsigned i = 0; i < NUM_ROWS; i++) begin
         if (warmup_rows[i].cfg_now) write_frames(warmup_rows[i].cfg_val);
         send_page(warmup_rows[i].page, warmup_rows[i].pinned, warmup_rows[i].want);
         pace_sender();
      end

      // random working-set phases, each under its own frame count
      for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
         write_frames((ph == 0) ? 3'd4 : 3'($urandom_range(0, 7)));
         pool_len = $urandom_range(2, 7);
         for (int unsigned k = 0; k < 8; k++) pool[k] = 16'($urandom());

         if (ph == 0) begin
            // long receiver hold-off while requests keep coming
            hold_off_req = 1'b1;
            extra = 0;
            while (hold_off_req || extra < 8) begin
               send_page(pick_page(pool, pool_len), 1'b0, '0);
               if (!hold_off_req) extra++;
            end
         end

         for (int unsigned i = 0; i < PHASE_LEN; i++) begin
            send_page(pick_page(pool, pool_len), 1'b0, '0);
            pace_sender();
         end
      end

      // wait out the tail, bounded
      @(negedge clock);
      req_tvalid <= 1'b0;
      guard = 0;
      while (expected_lookups.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 8) @(posedge clock);
      if (expected_lookups.size() != 0) begin
         $display("%0t ns: %0d results never arrived", $time, expected_lookups.size());
         errors += expected_lookups.size();
      end

      $display("run covered %0d page references, %0d results (%0d hits, %0d evictions)",
               n_requests, n_results, n_hits, n_evictions);
      $display("with %0d frame count writes, a long receiver hold-off and full drains",
               n_cfg);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("timeout: stimulus or results stalled");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/lrupr_pkg.sv
rtl/lru_page_replacement.sv
test/tb_top.sv
